### design/aalr_pkg.sv
// Shared types and constants for the antialiased line rasterizer.
`timescale 1ns / 1ps
package aalr_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COLOR_W = 8;
  localparam int IBITS_W = 4;
  localparam int LEVELS_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS = 2'd2;

  localparam logic [COLOR_W-1:0] BASE_COLOR_RST = 8'd255;
  localparam logic [IBITS_W-1:0] INTENSITY_BITS_RST = 4'd8;
  localparam logic [LEVELS_W-1:0] NUM_LEVELS_RST = 9'd256;

  // depth of the queue between classifier and sequencer
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_HORIZ  = 3'd1,
    MODE_VERT   = 3'd2,
    MODE_DIAG   = 3'd3,
    MODE_YMAJOR = 3'd4,
    MODE_XMAJOR = 3'd5
  } mode_t;

  // classification of one queued item
  typedef struct packed {
    logic  is_adv;
    mode_t mode;
    logic  x_neg;
  } cls_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_PAIR = 2'd2
  } back_state_t;

endpackage

### design/aalr_front.sv
// Front end: orders endpoints top to bottom and classifies the line.
`timescale 1ns / 1ps
module aalr_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                  opcode,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output aalr_pkg::cls_t        cls,
  output logic [COORD_BITS-1:0] sx,
  output logic [COORD_BITS-1:0] sy,
  output logic [COORD_BITS-1:0] ex,
  output logic [COORD_BITS-1:0] ey,
  output logic [COORD_BITS-1:0] steps,
  output logic [COORD_BITS-1:0] minor
);
  import aalr_pkg::*;

  logic                  swap;
  logic                  neg;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  always_comb begin
    swap = start_y > end_y;
    sx = swap ? end_x : start_x;
    sy = swap ? end_y : start_y;
    ex = swap ? start_x : end_x;
    ey = swap ? start_y : end_y;
    neg = ex < sx;
    dx = neg ? sx - ex : ex - sx;
    dy = ey - sy;

    cls.is_adv = opcode;
    cls.x_neg = neg;
    if (dy == '0) begin
      cls.mode = (dx == '0) ? MODE_IDLE : MODE_HORIZ;
      steps = dx;
      minor = '0;
    end else if (dx == '0) begin
      cls.mode = MODE_VERT;
      steps = dy;
      minor = '0;
    end else if (dx == dy) begin
      cls.mode = MODE_DIAG;
      steps = dy;
      minor = '0;
    end else if (dy > dx) begin
      cls.mode = MODE_YMAJOR;
      steps = dy;
      minor = dx;
    end else begin
      cls.mode = MODE_XMAJOR;
      steps = dx;
      minor = dy;
    end
  end

endmodule

### design/aalr_fifo.sv
// Short queue between the front end and the pixel sequencer.
`timescale 1ns / 1ps
module aalr_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              full,
  output logic              nonempty
);
  import aalr_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [DATA_W-1:0] slots [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full = count == CNT_W'(QDEPTH);
  assign nonempty = count != '0;
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/aalr_div.sv
// Restoring divider, one quotient bit per cycle: quot = num * 2^Q_W / den.
`timescale 1ns / 1ps
module aalr_div #(
  parameter int NUM_W = 10,
  parameter int Q_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quot
);
  import aalr_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] divisor;
  logic [CNT_W-1:0] count;
  logic [NUM_W:0]   shifted;
  logic             fits;

  // num < den, so the partial remainder always stays below den
  assign shifted = {rem, 1'b0};
  assign fits = shifted >= {1'b0, divisor};
  assign busy = count != '0;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      divisor <= den;
      quot <= '0;
    end else if (busy) begin
      rem <= fits ? NUM_W'(shifted - {1'b0, divisor}) : shifted[NUM_W-1:0];
      quot <= {quot[Q_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(Q_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

endmodule

### design/aalr_back.sv
// Pixel sequencer: walks the line, runs the slope division, holds the output register.
`timescale 1ns / 1ps
module aalr_back #(
  parameter int COORD_BITS = 10,
  parameter int ERROR_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  aalr_pkg::cls_t                q_cls,
  input  logic [COORD_BITS-1:0]         q_sx,
  input  logic [COORD_BITS-1:0]         q_sy,
  input  logic [COORD_BITS-1:0]         q_ex,
  input  logic [COORD_BITS-1:0]         q_ey,
  input  logic [COORD_BITS-1:0]         q_steps,
  input  logic [COORD_BITS-1:0]         q_minor,
  output logic                          q_pop,
  input  logic [aalr_pkg::COLOR_W-1:0]  base_color,
  input  logic [aalr_pkg::IBITS_W-1:0]  intensity_bits,
  input  logic [aalr_pkg::LEVELS_W-1:0] num_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [aalr_pkg::COLOR_W-1:0]  intensity,
  output logic                          run_last,
  output logic                          line_done
);
  import aalr_pkg::*;

  localparam int W_BITS = (1 << IBITS_W) - 1;
  localparam int SH_W = $clog2(ERROR_BITS + 1);

  function automatic logic [COLOR_W-1:0] sat_level(input logic [W_BITS-1:0] w,
                                                   input logic [COLOR_W-1:0] base);
    logic [COLOR_W-1:0] lvl;
    lvl = (w > W_BITS'(base)) ? '0 : base - w[COLOR_W-1:0];
    return lvl;
  endfunction

  back_state_t           state, state_next;
  mode_t                 mode, mode_next;
  logic [COORD_BITS-1:0] cur_x, cur_x_next;
  logic [COORD_BITS-1:0] cur_y, cur_y_next;
  logic [COORD_BITS-1:0] fin_x, fin_x_next;
  logic [COORD_BITS-1:0] fin_y, fin_y_next;
  logic [COORD_BITS-1:0] step_left, step_left_next;
  logic                  x_neg, x_neg_next;
  logic [ERROR_BITS-1:0] err_acc, err_acc_next;
  logic [ERROR_BITS-1:0] err_adj, err_adj_next;
  logic [COORD_BITS-1:0] pair_x, pair_x_next;
  logic [COORD_BITS-1:0] pair_y, pair_y_next;
  logic [COLOR_W-1:0]    pair_int, pair_int_next;
  logic                  out_valid_next;
  logic [COORD_BITS-1:0] pixel_x_next;
  logic [COORD_BITS-1:0] pixel_y_next;
  logic [COLOR_W-1:0]    intensity_next;
  logic                  run_last_next;
  logic                  line_done_next;

  logic                  div_start;
  logic                  div_busy;
  logic [ERROR_BITS-1:0] div_quot;

  logic                  slot_free;
  logic [ERROR_BITS-1:0] acc_sum;
  logic                  carry;
  logic [SH_W-1:0]       shamt;
  logic [ERROR_BITS-1:0] acc_shift;
  logic [W_BITS-1:0]     w;
  logic [LEVELS_W-1:0]   lvl_mask;
  logic [W_BITS-1:0]     w_inv;
  logic [COORD_BITS-1:0] x_step;
  logic [COORD_BITS-1:0] y_step;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_y;

  aalr_div #(
    .NUM_W(COORD_BITS),
    .Q_W  (ERROR_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (q_minor),
    .den  (q_steps),
    .busy (div_busy),
    .quot (div_quot)
  );

  // weighting for the next pair step
  always_comb begin
    acc_sum = err_acc + err_adj;
    carry = acc_sum <= err_acc;
    shamt = SH_W'(ERROR_BITS) - SH_W'(intensity_bits);
    acc_shift = acc_sum >> shamt;
    w = (intensity_bits != '0) ? acc_shift[W_BITS-1:0] : '0;
    lvl_mask = num_levels - 1'b1;
    w_inv = w ^ W_BITS'(lvl_mask);
    x_step = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
    y_step = cur_y + 1'b1;
  end

  always_comb begin
    state_next = state;
    mode_next = mode;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    fin_x_next = fin_x;
    fin_y_next = fin_y;
    step_left_next = step_left;
    x_neg_next = x_neg;
    err_acc_next = err_acc;
    err_adj_next = err_adj;
    pair_x_next = pair_x;
    pair_y_next = pair_y;
    pair_int_next = pair_int;
    pixel_x_next = pixel_x;
    pixel_y_next = pixel_y;
    intensity_next = intensity;
    run_last_next = run_last;
    line_done_next = line_done;
    q_pop = 1'b0;
    div_start = 1'b0;
    new_x = cur_x;
    new_y = cur_y;

    slot_free = !out_valid || !out_stall;
    out_valid_next = out_valid && out_stall;

    case (state)
      B_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (!q_cls.is_adv) begin
            mode_next = q_cls.mode;
            cur_x_next = q_sx;
            cur_y_next = q_sy;
            fin_x_next = q_ex;
            fin_y_next = q_ey;
            step_left_next = q_steps;
            x_neg_next = q_cls.x_neg;
            err_acc_next = '0;
            err_adj_next = '0;
            out_valid_next = 1'b1;
            pixel_x_next = q_sx;
            pixel_y_next = q_sy;
            intensity_next = base_color;
            run_last_next = 1'b1;
            line_done_next = q_cls.mode == MODE_IDLE;
            if (q_cls.mode inside {MODE_YMAJOR, MODE_XMAJOR}) begin
              div_start = 1'b1;
              state_next = B_DIV;
            end
          end else begin
            case (mode)
              MODE_IDLE: begin
              end
              MODE_HORIZ, MODE_VERT, MODE_DIAG: begin
                new_x = (mode != MODE_VERT) ? x_step : cur_x;
                new_y = (mode != MODE_HORIZ) ? y_step : cur_y;
                cur_x_next = new_x;
                cur_y_next = new_y;
                step_left_next = step_left - 1'b1;
                if (step_left == COORD_BITS'(1)) begin
                  mode_next = MODE_IDLE;
                end
                out_valid_next = 1'b1;
                pixel_x_next = new_x;
                pixel_y_next = new_y;
                intensity_next = base_color;
                run_last_next = 1'b1;
                line_done_next = step_left == COORD_BITS'(1);
              end
              MODE_YMAJOR, MODE_XMAJOR: begin
                out_valid_next = 1'b1;
                if (step_left <= COORD_BITS'(1)) begin
                  mode_next = MODE_IDLE;
                  step_left_next = '0;
                  pixel_x_next = fin_x;
                  pixel_y_next = fin_y;
                  intensity_next = base_color;
                  run_last_next = 1'b1;
                  line_done_next = 1'b1;
                end else begin
                  err_acc_next = acc_sum;
                  step_left_next = step_left - 1'b1;
                  if (mode == MODE_YMAJOR) begin
                    new_x = carry ? x_step : cur_x;
                    new_y = y_step;
                    pair_x_next = x_neg ? new_x - 1'b1 : new_x + 1'b1;
                    pair_y_next = new_y;
                  end else begin
                    new_x = x_step;
                    new_y = carry ? y_step : cur_y;
                    pair_x_next = new_x;
                    pair_y_next = new_y + 1'b1;
                  end
                  cur_x_next = new_x;
                  cur_y_next = new_y;
                  pair_int_next = sat_level(w_inv, base_color);
                  pixel_x_next = new_x;
                  pixel_y_next = new_y;
                  intensity_next = sat_level(w, base_color);
                  run_last_next = 1'b0;
                  line_done_next = 1'b0;
                  state_next = B_PAIR;
                end
              end
              default: begin
                mode_next = MODE_IDLE;
              end
            endcase
          end
        end
      end
      B_DIV: begin
        if (!div_busy) begin
          err_adj_next = div_quot;
          state_next = B_IDLE;
        end
      end
      B_PAIR: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          pixel_x_next = pair_x;
          pixel_y_next = pair_y;
          intensity_next = pair_int;
          run_last_next = 1'b1;
          line_done_next = 1'b0;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      mode <= MODE_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_x <= cur_x_next;
    cur_y <= cur_y_next;
    fin_x <= fin_x_next;
    fin_y <= fin_y_next;
    step_left <= step_left_next;
    x_neg <= x_neg_next;
    err_acc <= err_acc_next;
    err_adj <= err_adj_next;
    pair_x <= pair_x_next;
    pair_y <= pair_y_next;
    pair_int <= pair_int_next;
    pixel_x <= pixel_x_next;
    pixel_y <= pixel_y_next;
    intensity <= intensity_next;
    run_last <= run_last_next;
    line_done <= line_done_next;
  end

endmodule

### design/antialiased_line_rasterizer.sv
// Top level of the antialiased line rasterizer: config registers, front end, queue, sequencer.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   opcode, start_x, start_y, end_x, end_y
//   out      output     out_valid / out_stall pixel_x, pixel_y, intensity, run_last, line_done
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Start: first pixel in the cycle after leaving the queue; a line that is neither horizontal,
// vertical nor diagonal then keeps the next item in the queue during the serial divide and
// the quotient load. Advance: a single pixel, or a pair whose partner waits in B_PAIR.
// The queue holds two classified items, so in_stall rises only when both are waiting.
// out_stall holds the output register; the sequencer waits until it is free.
// rst is synchronous and clears the queue, the sequencer and the config registers.
`timescale 1ns / 1ps
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int ERROR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [COORD_BITS-1:0]           start_x,
  input  logic [COORD_BITS-1:0]           start_y,
  input  logic [COORD_BITS-1:0]           end_x,
  input  logic [COORD_BITS-1:0]           end_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [COORD_BITS-1:0]           pixel_x,
  output logic [COORD_BITS-1:0]           pixel_y,
  output logic [aalr_pkg::COLOR_W-1:0]    intensity,
  output logic                            run_last,
  output logic                            line_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aalr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aalr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aalr_pkg::*;

  localparam int CLS_W = $bits(cls_t);
  localparam int ENTRY_W = CLS_W + 6 * COORD_BITS;

  logic [COLOR_W-1:0]    base_color;
  logic [IBITS_W-1:0]    intensity_bits;
  logic [LEVELS_W-1:0]   num_levels;

  cls_t                  f_cls;
  logic [COORD_BITS-1:0] f_sx, f_sy, f_ex, f_ey, f_steps, f_minor;
  logic [ENTRY_W-1:0]    q_wdata;
  logic [ENTRY_W-1:0]    q_rdata;
  logic                  q_full;
  logic                  q_nonempty;
  logic                  q_pop;

  cls_t                  q_cls;
  logic [COORD_BITS-1:0] q_sx, q_sy, q_ex, q_ey, q_steps, q_minor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_color <= BASE_COLOR_RST;
      intensity_bits <= INTENSITY_BITS_RST;
      num_levels <= NUM_LEVELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_COLOR:     base_color <= cfg_data[COLOR_W-1:0];
        CFG_INTENSITY_BITS: intensity_bits <= cfg_data[IBITS_W-1:0];
        CFG_NUM_LEVELS:     num_levels <= cfg_data[LEVELS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aalr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .opcode (opcode),
    .start_x(start_x),
    .start_y(start_y),
    .end_x  (end_x),
    .end_y  (end_y),
    .cls    (f_cls),
    .sx     (f_sx),
    .sy     (f_sy),
    .ex     (f_ex),
    .ey     (f_ey),
    .steps  (f_steps),
    .minor  (f_minor)
  );

  assign q_wdata = {f_cls, f_sx, f_sy, f_ex, f_ey, f_steps, f_minor};
  assign in_stall = q_full;

  aalr_fifo #(
    .DATA_W(ENTRY_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (in_valid),
    .wdata   (q_wdata),
    .pop     (q_pop),
    .rdata   (q_rdata),
    .full    (q_full),
    .nonempty(q_nonempty)
  );

  assign {q_cls, q_sx, q_sy, q_ex, q_ey, q_steps, q_minor} = q_rdata;

  aalr_back #(
    .COORD_BITS(COORD_BITS),
    .ERROR_BITS(ERROR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_nonempty),
    .q_cls         (q_cls),
    .q_sx          (q_sx),
    .q_sy          (q_sy),
    .q_ex          (q_ex),
    .q_ey          (q_ey),
    .q_steps       (q_steps),
    .q_minor       (q_minor),
    .q_pop         (q_pop),
    .base_color    (base_color),
    .intensity_bits(intensity_bits),
    .num_levels    (num_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .intensity     (intensity),
    .run_last      (run_last),
    .line_done     (line_done)
  );

endmodule

### design/aalr_checker.sv
// Port-level assertions for the antialiased line rasterizer, bound to the top level.
`timescale 1ns / 1ps
module aalr_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [COORD_BITS-1:0]          pixel_x,
  input logic [COORD_BITS-1:0]          pixel_y,
  input logic [aalr_pkg::COLOR_W-1:0]   intensity,
  input logic                           run_last,
  input logic                           line_done
);
  import aalr_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(intensity) && $stable(run_last) && $stable(line_done))
    else $error("stalled output changed");

  // the end of a line is always the last pixel of its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> run_last)
    else $error("line_done without run_last");

  // first pixel of a pair is followed at once by its partner in the same row or column
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid && run_last && !line_done
      && (pixel_x == $past(pixel_x) || pixel_y == $past(pixel_y)))
    else $error("pair partner missing or misplaced");

endmodule

bind antialiased_line_rasterizer aalr_checker #(
  .COORD_BITS(COORD_BITS)
) u_aalr_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .pixel_x  (pixel_x),
  .pixel_y  (pixel_y),
  .intensity(intensity),
  .run_last (run_last),
  .line_done(line_done)
);

### tb/antialiased_line_rasterizer_tb.sv
// Self-checking testbench for the antialiased line rasterizer: pixel predictor plus drivers.
`timescale 1ns / 1ps
module antialiased_line_rasterizer_tb;
  import aalr_pkg::*;

  localparam int CW = 10;
  localparam int EW = 32;
  localparam logic OP_START = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int PHASE_ITEMS = 86;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [COLOR_W-1:0] level;
    logic last;
    logic done;
  } pixel_t;

  class pixel_scoreboard;
    logic [COLOR_W-1:0] base_color;
    logic [IBITS_W-1:0] ibits;
    logic [LEVELS_W-1:0] nlevels;
    logic [CW-1:0] cur_x, cur_y, end_px, end_py, steps_left;
    logic x_neg;
    logic [EW-1:0] err_acc, err_adj;
    mode_t mode;
    pixel_t expected_pixels[$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
      reset();
    endfunction

    function void reset();
      base_color = BASE_COLOR_RST;
      ibits = INTENSITY_BITS_RST;
      nlevels = NUM_LEVELS_RST;
      cur_x = '0;
      cur_y = '0;
      end_px = '0;
      end_py = '0;
      steps_left = '0;
      x_neg = 1'b0;
      err_acc = '0;
      err_adj = '0;
      mode = MODE_IDLE;
      expected_pixels.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE_COLOR: base_color = data[COLOR_W-1:0];
        CFG_INTENSITY_BITS: ibits = data[IBITS_W-1:0];
        CFG_NUM_LEVELS: nlevels = data[LEVELS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function bit line_active();
      return mode != MODE_IDLE;
    endfunction

    function logic [CW-1:0] step_x(logic [CW-1:0] x);
      return x_neg ? x - 1'b1 : x + 1'b1;
    endfunction

    function logic [COLOR_W-1:0] shade(logic [EW-1:0] w);
      if (w > EW'(base_color)) return '0;
      return base_color - w[COLOR_W-1:0];
    endfunction

    function void push_pixel(logic [CW-1:0] x, logic [CW-1:0] y, logic [COLOR_W-1:0] level,
                             logic last, logic done);
      pixel_t p;
      p.x = x;
      p.y = y;
      p.level = level;
      p.last = last;
      p.done = done;
      expected_pixels.push_back(p);
    endfunction

    // returns the number of pixels the item should produce
    function int note_item(logic op, logic [CW-1:0] sx, logic [CW-1:0] sy,
                           logic [CW-1:0] ex, logic [CW-1:0] ey);
      logic [CW-1:0] x0, y0, x1, y1, dx, dy;
      logic [EW-1:0] prev, w, wm;
      logic [LEVELS_W-1:0] lmask;
      logic carry;
      logic [63:0] num;
      if (op == OP_START) begin
        if (sy > ey) begin
          x0 = ex; y0 = ey; x1 = sx; y1 = sy;
        end else begin
          x0 = sx; y0 = sy; x1 = ex; y1 = ey;
        end
        cur_x = x0;
        cur_y = y0;
        end_px = x1;
        end_py = y1;
        x_neg = x1 < x0;
        dx = x_neg ? x0 - x1 : x1 - x0;
        dy = y1 - y0;
        err_acc = '0;
        err_adj = '0;
        if (dy == 0) begin
          mode = (dx == 0) ? MODE_IDLE : MODE_HORIZ;
          steps_left = dx;
        end else if (dx == 0) begin
          mode = MODE_VERT;
          steps_left = dy;
        end else if (dx == dy) begin
          mode = MODE_DIAG;
          steps_left = dy;
        end else if (dy > dx) begin
          mode = MODE_YMAJOR;
          num = {22'd0, dx, 32'd0};
          err_adj = EW'(num / {54'd0, dy});
          steps_left = dy;
        end else begin
          mode = MODE_XMAJOR;
          num = {22'd0, dy, 32'd0};
          err_adj = EW'(num / {54'd0, dx});
          steps_left = dx;
        end
        push_pixel(cur_x, cur_y, base_color, 1'b1, mode == MODE_IDLE);
        return 1;
      end
      if (mode == MODE_IDLE) return 0;
      if (mode inside {MODE_HORIZ, MODE_VERT, MODE_DIAG}) begin
        if (mode != MODE_VERT) cur_x = step_x(cur_x);
        if (mode != MODE_HORIZ) cur_y = cur_y + 1'b1;
        steps_left = steps_left - 1'b1;
        push_pixel(cur_x, cur_y, base_color, 1'b1, steps_left == 0);
        if (steps_left == 0) mode = MODE_IDLE;
        return 1;
      end
      // last step of a weighted line lands exactly on the end point
      if (steps_left <= 1) begin
        mode = MODE_IDLE;
        steps_left = '0;
        push_pixel(end_px, end_py, base_color, 1'b1, 1'b1);
        return 1;
      end
      prev = err_acc;
      err_acc = err_acc + err_adj;
      carry = err_acc <= prev;
      w = (ibits != 0) ? err_acc >> (EW - ibits) : '0;
      // level mask wraps at the register width
      lmask = nlevels - 1'b1;
      wm = w ^ EW'(lmask);
      if (mode == MODE_YMAJOR) begin
        if (carry) cur_x = step_x(cur_x);
        cur_y = cur_y + 1'b1;
        push_pixel(cur_x, cur_y, shade(w), 1'b0, 1'b0);
        push_pixel(step_x(cur_x), cur_y, shade(wm), 1'b1, 1'b0);
      end else begin
        if (carry) cur_y = cur_y + 1'b1;
        cur_x = step_x(cur_x);
        push_pixel(cur_x, cur_y, shade(w), 1'b0, 1'b0);
        push_pixel(cur_x, cur_y + 1'b1, shade(wm), 1'b1, 1'b0);
      end
      steps_left = steps_left - 1'b1;
      return 2;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel with nothing expected: x %0d, y %0d", got.x, got.y);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      compare_field("pixel_x", want.x, got.x);
      compare_field("pixel_y", want.y, got.y);
      compare_field("intensity", want.level, got.level);
      compare_field("run_last", want.last, got.last);
      compare_field("line_done", want.done, got.done);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic opcode;
  logic [CW-1:0] start_x, start_y, end_x, end_y;
  logic out_valid;
  logic out_stall;
  logic [CW-1:0] pixel_x, pixel_y;
  logic [COLOR_W-1:0] intensity;
  logic run_last;
  logic line_done;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard sb;
  pixel_t seen_pixel;
  bit idle_en;
  bit stall_on;
  bit long_hold;
  int last_results;
  int n_items;
  int n_starts;
  int n_steps;
  int n_settings;
  int cycles;

  antialiased_line_rasterizer #(
    .COORD_BITS(CW),
    .ERROR_BITS(EW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .intensity(intensity),
    .run_last(run_last),
    .line_done(line_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_pixel.x = pixel_x;
      seen_pixel.y = pixel_y;
      seen_pixel.level = intensity;
      seen_pixel.last = run_last;
      seen_pixel.done = line_done;
      sb.check_pixel(seen_pixel);
    end
  end

  // receiver: short random stall bursts, one long hold on request
  initial begin
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [CW-1:0] rnd_coord();
    return CW'($urandom_range(0, (1 << CW) - 1));
  endfunction

  // returns at the edge where the item is transferred
  task automatic send_item(input logic op, input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                           input logic [CW-1:0] ex, input logic [CW-1:0] ey);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_results = sb.note_item(op, sx, sy, ex, ey);
    if (last_results > 0) begin
      n_items++;
      if (op == OP_START) n_starts++;
      else n_steps++;
    end
  endtask

  task automatic advance();
    send_item(OP_ADVANCE, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  // sender pause: wait for every expected pixel, then let the divider finish
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] bc, input logic [CFG_DATA_W-1:0] ib,
                                input logic [CFG_DATA_W-1:0] nl);
    drain_outputs();
    cfg_write(CFG_BASE_COLOR, bc);
    cfg_write(CFG_INTENSITY_BITS, ib);
    cfg_write(CFG_NUM_LEVELS, nl);
    n_settings++;
  endtask

  task automatic run_directed();
    send_item(OP_START, 10'd0, 10'd0, 10'd0, 10'd0);           // single point
    advance();                                                  // nothing active
    send_item(OP_START, 10'd1023, 10'd5, 10'd1020, 10'd5);     // horizontal, leftward
    repeat (3) advance();
    send_item(OP_START, 10'd7, 10'd1023, 10'd7, 10'd1021);     // vertical, swapped
    repeat (2) advance();
    send_item(OP_START, 10'd1023, 10'd0, 10'd1021, 10'd2);     // diagonal, leftward
    repeat (2) advance();
    send_item(OP_START, 10'd3, 10'd3, 10'd900, 10'd1000);      // dropped by the next start
    advance();
    send_item(OP_START, 10'd1023, 10'd1023, 10'd1019, 10'd1021); // x-major, swapped
    repeat (4) advance();
    send_item(OP_START, 10'd10, 10'd20, 10'd12, 10'd24);       // y-major
    repeat (4) advance();
  endtask

  task automatic run_random_lines(input int target);
    int useful;
    int shape;
    int plan;
    int n;
    int m;
    int dx;
    int dy;
    logic [CW-1:0] sx, sy, ex, ey;
    useful = 0;
    while (useful < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(1'($urandom_range(0, 1)), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        if (last_results > 0) useful++;
      end else begin
        sx = rnd_coord();
        sy = rnd_coord();
        n = $urandom_range(1, 10);
        shape = $urandom_range(0, 11);
        case (shape)
          0: begin dx = 0; dy = 0; end
          1: begin dx = $urandom_range(0, 1) ? n : -n; dy = 0; end
          2: begin dx = 0; dy = $urandom_range(0, 1) ? n : -n; end
          3: begin dx = $urandom_range(0, 1) ? n : -n; dy = $urandom_range(0, 1) ? n : -n; end
          default: begin dx = $urandom_range(0, 24) - 12; dy = $urandom_range(0, 24) - 12; end
        endcase
        ex = sx + CW'(dx);
        ey = sy + CW'(dy);
        if (shape == 4) begin
          ex = rnd_coord();
          ey = rnd_coord();
        end
        send_item(OP_START, sx, sy, ex, ey);
        useful++;
        plan = $urandom_range(0, 9);
        n = 0;
        if (plan < 2) begin
          // cut short, the next start replaces the line
          m = $urandom_range(0, 3);
          while (n < m && sb.line_active()) begin
            advance();
            n++;
            useful++;
          end
        end else begin
          while (sb.line_active() && n < 48) begin
            advance();
            n++;
            useful++;
          end
          if (plan == 9) begin
            advance();
            if (last_results > 0) useful++;
          end
        end
      end
    end
  endtask

  logic [CFG_DATA_W-1:0] base_tab[1:6] = '{9'h080, 9'h000, 9'h1FF, 9'h1C8, 9'h03F, 9'h0FF};
  logic [CFG_DATA_W-1:0] ibits_tab[1:6] = '{9'h004, 9'h001, 9'h000, 9'h00F, 9'h1F3, 9'h008};
  logic [CFG_DATA_W-1:0] levels_tab[1:6] = '{9'h010, 9'h002, 9'h100, 9'd100, 9'h000, 9'h100};

  initial begin
    int ib;
    sb = new();
    idle_en = 1'b1;
    stall_on = 1'b1;
    long_hold = 1'b0;
    cycles = 0;
    n_items = 0;
    n_starts = 0;
    n_steps = 0;
    n_settings = 1;
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= OP_START;
    start_x <= '0;
    start_y <= '0;
    end_x <= '0;
    end_y <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE_COLOR;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random_lines(PHASE_ITEMS - 24);

    for (int p = 1; p <= 7; p++) begin
      if (p < 7) begin
        apply_settings(base_tab[p], ibits_tab[p], levels_tab[p]);
      end else begin
        ib = $urandom_range(1, 8);
        apply_settings(CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'(ib),
                       CFG_DATA_W'(1 << ib));
        idle_en = 1'b0;
        stall_on = 1'b0;
      end
      if (p == 2) cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 511)));
      // receiver holds off while the sender keeps pushing
      if (p == 1) long_hold = 1'b1;
      run_random_lines(PHASE_ITEMS / 2);
      if (p == 3) drain_outputs();
      run_random_lines(PHASE_ITEMS / 2);
    end

    drain_outputs();
    $display("Covered %0d items (%0d line starts, %0d steps) under %0d register settings;",
             n_items, n_starts, n_steps, n_settings);
    $display("%0d pixels compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/aalr_pkg.sv
design/aalr_front.sv
design/aalr_fifo.sv
design/aalr_div.sv
design/aalr_back.sv
design/antialiased_line_rasterizer.sv
design/aalr_checker.sv
tb/antialiased_line_rasterizer_tb.sv
